/* hdl/idf_pkg.sv */
`default_nettype none

package idf_pkg;

  localparam int SEQ_W      = 64;
  localparam int BOOT_W     = 64;
  localparam int CHAR_W     = 7;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  localparam int B32_CHARS  = 26;
  localparam int B32_MAX    = 26;
  localparam int B32_N      = (B32_CHARS > B32_MAX) ? B32_MAX :
                              ((B32_CHARS < 1) ? 1 : B32_CHARS);
  localparam int B32_BITS   = 5 * B32_N;
  localparam int B32_CNT_W  = $clog2(B32_N + 1);

  localparam int DEC_DIGITS = 20;
  localparam int BCD_BITS   = 4 * DEC_DIGITS;
  localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);
  localparam int BIN_CNT_W  = $clog2(SEQ_W + 1);

  localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;

  localparam logic REG_BOOT_HIGH = 1'b0;
  localparam logic REG_BOOT_LOW  = 1'b1;

  localparam logic [CHAR_W-1:0] B32_SYM [0:31] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
    7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B32,
    ST_HYPHEN,
    ST_SKIP,
    ST_DEC
  } idf_state_t;

  typedef struct packed {
    logic start;
    logic shift_digit;
  } idf_bcd_ctl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } idf_bcd_sts_t;

endpackage

`default_nettype wire

/* hdl/idf_bcd.sv */
`default_nettype none

module idf_bcd
  import idf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire idf_bcd_ctl_t ctl,
  input  wire logic [SEQ_W-1:0] seq,
  output idf_bcd_sts_t      sts
);

  logic [SEQ_W-1:0]     bin_r, bin_nxt;
  logic [BCD_BITS-1:0]  bcd_r, bcd_nxt;
  logic [BIN_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BCD_BITS-1:0]  adj;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (ctl.start) begin
      bin_nxt = seq;
      bcd_nxt = '0;
      cnt_nxt = BIN_CNT_W'(SEQ_W);
    end else if (cnt_r != '0) begin
      bcd_nxt = {adj[BCD_BITS-2:0], bin_r[SEQ_W-1]};
      bin_nxt = bin_r << 1;
      cnt_nxt = cnt_r - BIN_CNT_W'(1);
    end else if (ctl.shift_digit) begin
      bcd_nxt = bcd_r << 4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts.done  = (cnt_r == '0);
  assign sts.digit = bcd_r[BCD_BITS-1 -: 4];

endmodule

`default_nettype wire

/* hdl/id_text_formatter.sv */
// Channel   Direction  Transaction carries
// in_       slave      sequence_number in in_tdata
// out_      master     one ASCII character in out_tdata, last_char as out_tlast
// cfg_      APB slave  boot_high at 0x0, boot_low at 0x8
//
// With an unstalled output, an item's time is set by the 64-step
// bit-serial binary to BCD conversion plus one step per decimal position.
// The base32 symbols and the hyphen leave while the conversion runs.
// Leading decimal zeros are dropped one per cycle after the conversion ends.
// Synchronous reset clears the boot registers, counters, state and out valid.
// A stalled output holds its character, and the next item waits until all
// characters of the current one have been produced.

`default_nettype none

module id_text_formatter
  import idf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SEQ_W-1:0]      in_tdata,     // [63:0] sequence_number
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,    // [6:0] char_code, [7] zero
  output logic                       out_tlast,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic [BOOT_W-1:0]    boot_high_r, boot_low_r;
  idf_state_t           state_r, state_nxt;
  logic [B32_BITS-1:0]  b32_sh_r, b32_sh_nxt;
  logic [B32_CNT_W-1:0] sym_cnt_r, sym_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_left_r, dig_left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 slot_free;
  logic                 in_acc;
  logic                 cfg_wr;
  idf_bcd_ctl_t         bcd_ctl;
  idf_bcd_sts_t         bcd_sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3])
      REG_BOOT_HIGH: cfg_prdata = boot_high_r;
      REG_BOOT_LOW:  cfg_prdata = boot_low_r;
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_high_r <= '0;
      boot_low_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3])
        REG_BOOT_HIGH: boot_high_r <= cfg_pwdata;
        REG_BOOT_LOW:  boot_low_r  <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  idf_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bcd_ctl),
    .seq   (in_tdata),
    .sts   (bcd_sts)
  );

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt           = state_r;
    b32_sh_nxt          = b32_sh_r;
    sym_cnt_nxt         = sym_cnt_r;
    dig_left_nxt        = dig_left_r;
    out_valid_nxt       = out_valid_r && !out_tready;
    out_char_nxt        = out_char_r;
    out_last_nxt        = out_last_r;
    bcd_ctl.start       = 1'b0;
    bcd_ctl.shift_digit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          b32_sh_nxt    = B32_BITS'({boot_high_r, boot_low_r});
          sym_cnt_nxt   = B32_CNT_W'(B32_N);
          dig_left_nxt  = DIG_CNT_W'(DEC_DIGITS);
          bcd_ctl.start = 1'b1;
          state_nxt     = ST_B32;
        end
      end
      ST_B32: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = B32_SYM[b32_sh_r[B32_BITS-1 -: 5]];
          out_last_nxt  = 1'b0;
          b32_sh_nxt    = b32_sh_r << 5;
          sym_cnt_nxt   = sym_cnt_r - B32_CNT_W'(1);
          if (sym_cnt_r == B32_CNT_W'(1)) begin
            state_nxt = ST_HYPHEN;
          end
        end
      end
      ST_HYPHEN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_HYPHEN;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (bcd_sts.done) begin
          if (bcd_sts.digit == 4'd0 && dig_left_r != DIG_CNT_W'(1)) begin
            bcd_ctl.shift_digit = 1'b1;
            dig_left_nxt        = dig_left_r - DIG_CNT_W'(1);
          end else begin
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_char_nxt        = CHAR_ZERO + CHAR_W'(bcd_sts.digit);
          out_last_nxt        = (dig_left_r == DIG_CNT_W'(1));
          bcd_ctl.shift_digit = 1'b1;
          dig_left_nxt        = dig_left_r - DIG_CNT_W'(1);
          if (dig_left_r == DIG_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sym_cnt_r   <= '0;
      dig_left_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      dig_left_r  <= dig_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b32_sh_r   <= b32_sh_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* hdl/idf_chk.sv */
`default_nettype none

module idf_chk
  import idf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [7:0]       out_tdata,
  input wire logic             out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled output transaction changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while a transaction is being formatted.");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7] == 1'b0 && out_tdata[6:0] >= 7'd45 && out_tdata[6:0] <= 7'd90)
    else $error("Output character outside the expected range.");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[6:0] >= 7'd48 && out_tdata[6:0] <= 7'd57)
    else $error("Final character is not a decimal digit.");

endmodule

bind id_text_formatter idf_chk u_idf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
